FILE: hw/rtl/cbp_pkg.sv
`default_nettype none
package cbp_pkg;

  // width_mode codes
  localparam logic [1:0] MODE_W4  = 2'd0;
  localparam logic [1:0] MODE_W7  = 2'd1;
  localparam logic [1:0] MODE_W13 = 2'd2;
  localparam logic [1:0] MODE_W15 = 2'd3;

  // configuration register indexes
  localparam logic [7:0] CFG_WIDTH_MODE     = 8'd0;
  localparam logic [7:0] CFG_COMPARE_ENABLE = 8'd1;

  localparam int unsigned ACC_W  = 22;
  localparam int unsigned HELD_W = 3;

  // one outgoing byte with its flags
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       mismatch_seen;
    logic       run_end;
    logic       stream_end;
  } out_beat_t;

  function automatic logic [3:0] coef_width(input logic [1:0] mode);
    logic [3:0] w;
    case (mode)
      MODE_W4:  w = 4'd4;
      MODE_W7:  w = 4'd7;
      MODE_W13: w = 4'd13;
      MODE_W15: w = 4'd15;
      default:  w = 4'd7;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] coef_mask(input logic [1:0] mode);
    logic [15:0] m;
    case (mode)
      MODE_W4:  m = 16'h000f;
      MODE_W7:  m = 16'h007f;
      MODE_W13: m = 16'h1fff;
      MODE_W15: m = 16'h7fff;
      default:  m = 16'h007f;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/coefficient_bit_packer.sv
`default_nettype none
// Coefficient bit packer.
// Input channel (in_valid/in_ready) takes one coefficient per beat with two
// expected bytes and a final_coefficient mark. Each coefficient is cut to the
// width chosen by width_mode and appended, LSB first, to the held bits.
// Output channel (out_valid/out_ready) gives one packed byte per beat, with
// the sticky mismatch flag, run_end on the last byte of a coefficient and
// stream_end on the last byte of a final coefficient.
// Configuration channel (cfg_valid/cfg_ready) writes width_mode (index 0) and
// compare_enable (index 1); it is always ready and other indexes are ignored.
// The first byte of a coefficient is offered the cycle after it is
// accepted. A coefficient is taken whenever the two-entry output buffer is
// empty or is emptied by the beat leaving that cycle, so a coefficient that
// completes two bytes holds off the next until its first byte has left.
// The output port gives one byte per cycle while the receiver is ready.
// Reset clears held bits, mismatch flag and output buffer, and restores
// width_mode to 7 bits and compare_enable to off. When the receiver stalls
// the buffered bytes hold and in_ready drops until room is made.
module coefficient_bit_packer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] coefficient,
  input  wire logic [7:0]  expected_first,
  input  wire logic [7:0]  expected_second,
  input  wire logic        final_coefficient,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       packed_byte,
  output logic             mismatch_seen,
  output logic             run_end,
  output logic             stream_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import cbp_pkg::*;

  logic [1:0]        width_mode;
  logic              compare_enable;
  logic [6:0]        acc;
  logic [HELD_W-1:0] held;
  logic              mismatch_flag;
  out_beat_t         slot0;
  out_beat_t         slot1;
  logic [1:0]        fill;

  logic              in_fire;
  logic              out_fire;
  logic [ACC_W-1:0]  merged;
  logic [4:0]        count;
  logic [1:0]        nbytes;
  logic [7:0]        byte0;
  logic [7:0]        byte1;
  logic              mis0;
  logic              mis1;
  logic [6:0]        acc_next;
  out_beat_t         beat0;
  out_beat_t         beat1;

  assign cfg_ready = 1'b1;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (fill == 2'd0) || ((fill == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;

  // merge the new coefficient above the held bits
  always_comb begin
    merged = {15'd0, acc} |
             ({6'd0, coefficient & coef_mask(width_mode)} << held);
    count  = {2'd0, held} + {1'b0, coef_width(width_mode)};
    if (count[4]) begin
      nbytes = 2'd2;
    end else if (count[3]) begin
      nbytes = 2'd1;
    end else begin
      nbytes = 2'd0;
    end
    byte0 = merged[7:0];
    byte1 = merged[15:8];
    mis0  = mismatch_flag ||
            (compare_enable && (nbytes != 2'd0) && (byte0 != expected_first));
    mis1  = mis0 ||
            (compare_enable && (nbytes == 2'd2) && (byte1 != expected_second));
    case (nbytes)
      2'd2:    acc_next = {1'b0, merged[21:16]};
      2'd1:    acc_next = merged[14:8];
      default: acc_next = merged[6:0];
    endcase
  end

  // build the outgoing beats
  always_comb begin
    beat0.packed_byte   = byte0;
    beat0.mismatch_seen = mis0;
    beat0.run_end       = (nbytes == 2'd1);
    beat0.stream_end    = (nbytes == 2'd1) && final_coefficient;
    beat1.packed_byte   = byte1;
    beat1.mismatch_seen = mis1;
    beat1.run_end       = 1'b1;
    beat1.stream_end    = final_coefficient;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode     <= MODE_W7;
      compare_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH_MODE) begin
        width_mode <= cfg_data[1:0];
      end else if (cfg_index == CFG_COMPARE_ENABLE) begin
        compare_enable <= cfg_data[0];
      end
    end
  end

  // packing state; drop held bits and flag after a final coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      held          <= '0;
      mismatch_flag <= 1'b0;
    end else if (in_fire) begin
      if (final_coefficient) begin
        acc           <= '0;
        held          <= '0;
        mismatch_flag <= 1'b0;
      end else begin
        acc           <= acc_next;
        held          <= count[HELD_W-1:0];
        mismatch_flag <= mis1;
      end
    end
  end

  // two-entry output buffer: advance on a beat out, load on a beat in
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (in_fire) begin
      fill <= nbytes;
    end else if (out_fire) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot0 <= beat0;
      slot1 <= beat1;
    end else if (out_fire) begin
      slot0 <= slot1;
    end
  end

  assign out_valid     = (fill != 2'd0);
  assign packed_byte   = slot0.packed_byte;
  assign mismatch_seen = slot0.mismatch_seen;
  assign run_end       = slot0.run_end;
  assign stream_end    = slot0.stream_end;

endmodule
`default_nettype wire
